FILE: rtl/core/page_allocator_size_class_reuse_core_macros.svh
// ----------------------------------------------------------------------------
// page_allocator_size_class_reuse_core_macros
// Assertion helpers shared by the allocator core.
// ----------------------------------------------------------------------------
`ifndef PAGE_ALLOCATOR_SIZE_CLASS_REUSE_CORE_MACROS_SVH
`define PAGE_ALLOCATOR_SIZE_CLASS_REUSE_CORE_MACROS_SVH

// same-cycle implication
`define PA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/pa_pkg.sv
// ----------------------------------------------------------------------------
// pa_pkg
// Types, constants and helpers for the size-class page allocator core.
// ----------------------------------------------------------------------------
package pa_pkg;

  localparam int PAGE_SHIFT = 16;
  localparam int MAX_PAGES  = 1024;
  localparam int CLS_W      = 10;
  localparam int LEN_W      = 11;
  localparam int OFF_W      = 26;
  localparam int WORD_W     = 32;
  localparam int WSEL_W     = 5;

  localparam logic       CMD_ALLOC  = 1'b0;
  localparam logic       CMD_FREE   = 1'b1;
  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_FREED   = 2'd1;
  localparam logic [1:0] ST_OOM     = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [31:0] request_bytes;
    logic [25:0] block_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [25:0] granted_offset;
    logic [10:0] granted_pages;
  } out_t;

  // {found, index of lowest set bit}
  function automatic logic [WSEL_W:0] lowest32(input logic [WORD_W-1:0] v);
    logic [WSEL_W:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, i[WSEL_W-1:0]};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/pa_ram.sv
// ----------------------------------------------------------------------------
// pa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/page_allocator_size_class_reuse_core.sv
// ----------------------------------------------------------------------------
// page_allocator_size_class_reuse_core
// Segregated free-list allocator over a pool of 64 KiB pages.
// ----------------------------------------------------------------------------
// Usage:
//   in_* takes one transaction per request: cmd alloc with a byte count, or
//   cmd free with a block byte offset. out_* returns one transaction per
//   request, in order. cfg_we/cfg_wdata set the pool size; write them only
//   while idle, as the block itself does not enforce this.
// Result paths: alloc by bump, by exact class reuse or by a larger class,
//   out of memory; free, and free of a non-block page. The paths differ in
//   the dependent registered memory reads: class bitmap word, list head,
//   then list link. One request is in flight at a time; the next is taken
//   the cycle after its result is registered.
// The class bitmap is 32 words of 32 bits with a 32-bit summary register;
// a word whose summary bit is clear reads as empty.
// Reset empties all classes, zeroes the bump pointer and sets the pool to
// 1024 pages, then a pass over all 1024 entries clears the block-length
// table with in_ready low. A stalled receiver holds the result register; a
// finished result waits in its final state and the next request is taken
// once the result register frees.
// ----------------------------------------------------------------------------
`include "page_allocator_size_class_reuse_core_macros.svh"

module page_allocator_size_class_reuse_core
  import pa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_A_EX = 4'd1;
  localparam logic [3:0] S_A_LG = 4'd2;
  localparam logic [3:0] S_A_NX = 4'd3;
  localparam logic [3:0] S_P_HD = 4'd4;
  localparam logic [3:0] S_P_LK = 4'd5;
  localparam logic [3:0] S_F_LN = 4'd6;
  localparam logic [3:0] S_F_WR = 4'd7;
  localparam logic [3:0] S_CLR  = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [10:0]       pool_r, bump_r, bump_nxt;
  logic [WORD_W-1:0] summary_r, summary_nxt;
  logic [15:0]       need_m1_r, need_m1_nxt;
  logic [CLS_W-1:0]  page_r, page_nxt;
  logic [CLS_W-1:0]  cls_r, cls_nxt;
  logic [CLS_W-1:0]  idx_r, idx_nxt;
  logic [CLS_W-1:0]  clr_r, clr_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [WSEL_W-1:0] wd_sel_r, wd_sel_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  // memory ports
  logic              hd_we, hd_re, lk_we, lk_re, ln_we, ln_re, wd_we, wd_re;
  logic [CLS_W-1:0]  hd_wa, hd_ra, lk_wa, lk_ra, ln_wa, ln_ra;
  logic [CLS_W-1:0]  hd_wd, hd_rd, lk_wd, lk_rd;
  logic [LEN_W-1:0]  ln_wd, ln_rd;
  logic [WSEL_W-1:0] wd_wa, wd_ra;
  logic [WORD_W-1:0] wd_wd, wd_rd;

  pa_ram #(.W(CLS_W), .D(MAX_PAGES)) u_head (
    .clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .re(hd_re), .raddr(hd_ra),
    .rdata(hd_rd));
  pa_ram #(.W(CLS_W), .D(MAX_PAGES)) u_link (
    .clk, .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .re(lk_re), .raddr(lk_ra),
    .rdata(lk_rd));
  pa_ram #(.W(LEN_W), .D(MAX_PAGES)) u_len (
    .clk, .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .re(ln_re), .raddr(ln_ra),
    .rdata(ln_rd));
  pa_ram #(.W(WORD_W), .D(WORD_W)) u_word (
    .clk, .we(wd_we), .waddr(wd_wa), .wdata(wd_wd), .re(wd_re), .raddr(wd_ra),
    .rdata(wd_rd));

  logic              out_free;
  logic [31:0]       bm1;
  logic [16:0]       need;
  logic [10:0]       usable;
  logic              fits;
  logic [WORD_W-1:0] eff_word, masked, s_gt, word_new;
  logic [WSEL_W:0]   pe_m, pe_s, pe_w;
  logic [CLS_W-1:0]  nc, fc;
  logic [LEN_W-1:0]  flen;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign bm1    = (in_data.request_bytes == 32'd0) ? 32'd0 : in_data.request_bytes - 32'd1;
  assign need   = {1'b0, need_m1_r} + 17'd1;
  assign usable = (pool_r < 11'(MAX_PAGES)) ? pool_r : 11'(MAX_PAGES);
  assign fits   = ({7'd0, bump_r} + {1'b0, need}) <= {7'd0, usable};

  // word read back is only meaningful while its summary bit is set
  assign eff_word = summary_r[wd_sel_r] ? wd_rd : '0;

  assign masked = eff_word & ({WORD_W{1'b1}} << cls_r[WSEL_W-1:0]);
  assign s_gt   = summary_r & (({WORD_W{1'b1}} << cls_r[CLS_W-1:WSEL_W]) << 1);
  assign pe_m   = lowest32(masked);
  assign pe_s   = lowest32(s_gt);
  assign pe_w   = lowest32(wd_rd);
  assign nc     = need_m1_r[CLS_W-1:0] + 10'd1;
  assign flen   = (page_r < bump_r[CLS_W-1:0] || bump_r[CLS_W]) ? ln_rd : '0;
  assign fc     = CLS_W'(len_r - 11'd1);
  assign word_new = word_r & ~(32'd1 << cls_r[WSEL_W-1:0]);

  always_comb begin
    state_nxt     = state_r;
    bump_nxt      = bump_r;
    summary_nxt   = summary_r;
    need_m1_nxt   = need_m1_r;
    page_nxt      = page_r;
    cls_nxt       = cls_r;
    idx_nxt       = idx_r;
    clr_nxt       = clr_r;
    word_nxt      = word_r;
    len_nxt       = len_r;
    wd_sel_nxt    = wd_sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    hd_we = 1'b0; hd_re = 1'b0; hd_wa = '0; hd_ra = '0; hd_wd = '0;
    lk_we = 1'b0; lk_re = 1'b0; lk_wa = '0; lk_ra = '0; lk_wd = '0;
    ln_we = 1'b0; ln_re = 1'b0; ln_wa = '0; ln_ra = '0; ln_wd = '0;
    wd_we = 1'b0; wd_re = 1'b0; wd_wa = '0; wd_ra = '0; wd_wd = '0;

    unique case (state_r)
      S_CLR: begin
        // zero the block-length table, one entry a cycle
        ln_we   = 1'b1;
        ln_wa   = clr_r;
        clr_nxt = clr_r + 10'd1;
        if (clr_r == CLS_W'(MAX_PAGES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          need_m1_nxt = bm1[31:PAGE_SHIFT];
          page_nxt    = in_data.block_offset[OFF_W-1:PAGE_SHIFT];
          if (in_data.cmd == CMD_ALLOC) begin
            wd_re      = 1'b1;
            wd_ra      = bm1[PAGE_SHIFT+CLS_W-1:PAGE_SHIFT+WSEL_W];
            wd_sel_nxt = wd_ra;
            state_nxt  = S_A_EX;
          end else begin
            ln_re     = 1'b1;
            ln_ra     = in_data.block_offset[OFF_W-1:PAGE_SHIFT];
            state_nxt = S_F_LN;
          end
        end
      end
      S_A_EX: begin
        if (need_m1_r[15:CLS_W] == '0 && eff_word[need_m1_r[WSEL_W-1:0]]) begin
          cls_nxt   = need_m1_r[CLS_W-1:0];
          word_nxt  = eff_word;
          hd_re     = 1'b1;
          hd_ra     = need_m1_r[CLS_W-1:0];
          state_nxt = S_P_HD;
        end else if (fits) begin
          if (out_free) begin
            ln_we         = 1'b1;
            ln_wa         = bump_r[CLS_W-1:0];
            ln_wd         = need[LEN_W-1:0];
            bump_nxt      = bump_r + need[LEN_W-1:0];
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{ST_ALLOC, {bump_r[CLS_W-1:0], 16'd0}, need[LEN_W-1:0]};
            state_nxt     = S_IDLE;
          end
        end else if (need_m1_r < 16'(MAX_PAGES - 1)) begin
          cls_nxt    = nc;
          wd_re      = 1'b1;
          wd_ra      = nc[CLS_W-1:WSEL_W];
          wd_sel_nxt = wd_ra;
          state_nxt  = S_A_LG;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{ST_OOM, '0, '0};
          state_nxt     = S_IDLE;
        end
      end
      S_A_LG: begin
        if (pe_m[WSEL_W]) begin
          cls_nxt   = {cls_r[CLS_W-1:WSEL_W], pe_m[WSEL_W-1:0]};
          word_nxt  = eff_word;
          hd_re     = 1'b1;
          hd_ra     = cls_nxt;
          state_nxt = S_P_HD;
        end else if (pe_s[WSEL_W]) begin
          cls_nxt    = {pe_s[WSEL_W-1:0], cls_r[WSEL_W-1:0]};
          wd_re      = 1'b1;
          wd_ra      = pe_s[WSEL_W-1:0];
          wd_sel_nxt = wd_ra;
          state_nxt  = S_A_NX;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{ST_OOM, '0, '0};
          state_nxt     = S_IDLE;
        end
      end
      S_A_NX: begin
        // summary bit set, so the word is nonzero
        cls_nxt   = {cls_r[CLS_W-1:WSEL_W], pe_w[WSEL_W-1:0]};
        word_nxt  = wd_rd;
        hd_re     = 1'b1;
        hd_ra     = cls_nxt;
        state_nxt = S_P_HD;
      end
      S_P_HD: begin
        idx_nxt   = hd_rd;
        lk_re     = 1'b1;
        lk_ra     = hd_rd;
        state_nxt = S_P_LK;
      end
      S_P_LK: begin
        if (out_free) begin
          if (lk_rd == idx_r) begin
            // last block of the class
            wd_we = 1'b1;
            wd_wa = cls_r[CLS_W-1:WSEL_W];
            wd_wd = word_new;
            summary_nxt[cls_r[CLS_W-1:WSEL_W]] = |word_new;
          end else begin
            hd_we = 1'b1;
            hd_wa = cls_r;
            hd_wd = lk_rd;
          end
          ln_we         = 1'b1;
          ln_wa         = idx_r;
          ln_wd         = {1'b0, cls_r} + 11'd1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{ST_ALLOC, {idx_r, 16'd0}, {1'b0, cls_r} + 11'd1};
          state_nxt     = S_IDLE;
        end
      end
      S_F_LN: begin
        if (flen == '0) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{ST_BADFREE, '0, '0};
            state_nxt     = S_IDLE;
          end
        end else begin
          len_nxt    = flen;
          cls_nxt    = CLS_W'(flen - 11'd1);
          wd_re      = 1'b1;
          wd_ra      = cls_nxt[CLS_W-1:WSEL_W];
          wd_sel_nxt = wd_ra;
          hd_re      = 1'b1;
          hd_ra      = cls_nxt;
          ln_we      = 1'b1;
          ln_wa      = page_r;
          ln_wd      = '0;
          state_nxt  = S_F_WR;
        end
      end
      S_F_WR: begin
        if (out_free) begin
          lk_we = 1'b1;
          lk_wa = page_r;
          lk_wd = eff_word[fc[WSEL_W-1:0]] ? hd_rd : page_r;
          hd_we = 1'b1;
          hd_wa = fc;
          hd_wd = page_r;
          wd_we = 1'b1;
          wd_wa = fc[CLS_W-1:WSEL_W];
          wd_wd = eff_word | (32'd1 << fc[WSEL_W-1:0]);
          summary_nxt[fc[CLS_W-1:WSEL_W]] = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{ST_FREED, '0, '0};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      pool_r      <= 11'(MAX_PAGES);
      bump_r      <= '0;
      summary_r   <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_r      <= cfg_we ? cfg_wdata : pool_r;
      bump_r      <= bump_nxt;
      summary_r   <= summary_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_m1_r  <= need_m1_nxt;
    page_r     <= page_nxt;
    cls_r      <= cls_nxt;
    idx_r      <= idx_nxt;
    word_r     <= word_nxt;
    len_r      <= len_nxt;
    wd_sel_r   <= wd_sel_nxt;
    out_data_r <= out_data_nxt;
  end

  `PA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, state_r != S_IDLE)
  `PA_ASSERT_IMP(a_bump_in_range, 1'b1, bump_r <= 11'(MAX_PAGES))
  `PA_ASSERT_IMP(a_alloc_has_pages, out_valid && out_data.status == ST_ALLOC,
                 out_data.granted_pages != '0)

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the size-class page allocator core: a queue-fed
// driver, a result monitor checked against a behavioral allocator model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import pa_pkg::*;

  localparam int WD_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic [10:0] cfg_wdata;

  page_allocator_size_class_reuse_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // allocator model state
  int unsigned pool_sz;
  int unsigned bump;
  int unsigned blk_len [MAX_PAGES];
  int unsigned cls_head [MAX_PAGES];
  int unsigned cls_link [MAX_PAGES];
  bit          cls_live [MAX_PAGES];

  in_t  pending_reqs [$];
  out_t expected_grants [$];
  int   errors;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_off;
  int   quiet_cycles;

  // acceptance flag from the last rising edge
  logic in_ready_seen;

  // shadow of live blocks, used to pick realistic frees
  int unsigned live_blocks [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic enqueue(in_t t);
    pending_reqs = {pending_reqs, t};
  endtask

  function automatic int unsigned pop_cls(int unsigned pages);
    int unsigned c;
    int unsigned idx;
    c = pages - 1;
    idx = cls_head[c];
    if (cls_link[idx] == idx) cls_live[c] = 1'b0;
    else cls_head[c] = cls_link[idx];
    blk_len[idx] = pages;
    return idx;
  endfunction

  function automatic out_t predict_grant(in_t req);
    out_t r;
    longint unsigned bytes;
    longint unsigned need;
    int unsigned idx;
    int unsigned got;
    int unsigned pg;
    int unsigned len;
    int unsigned usable;
    r = '0;
    idx = 0;
    got = 0;
    if (req.cmd == CMD_ALLOC) begin
      bytes = 64'(req.request_bytes);
      if (bytes == 0) bytes = 1;
      need = (bytes + 64'd65535) >> PAGE_SHIFT;
      usable = (pool_sz < MAX_PAGES) ? pool_sz : MAX_PAGES;
      if (need <= MAX_PAGES && cls_live[need-1]) begin
        got = 32'(need);
        idx = pop_cls(got);
      end else if (bump + need <= usable) begin
        got = 32'(need);
        idx = bump;
        blk_len[idx] = got;
        bump += got;
      end else if (need < MAX_PAGES) begin
        for (int k = int'(need) + 1; k <= MAX_PAGES; k++) begin
          if (cls_live[k-1]) begin
            got = k;
            idx = pop_cls(k);
            break;
          end
        end
      end
      if (got != 0) begin
        r.status = ST_ALLOC;
        r.granted_offset = OFF_W'(idx << PAGE_SHIFT);
        r.granted_pages = LEN_W'(got);
        live_blocks = {live_blocks, idx};
      end else begin
        r.status = ST_OOM;
      end
    end else begin
      pg = 32'(req.block_offset >> PAGE_SHIFT);
      if (pg < MAX_PAGES && blk_len[pg] != 0) begin
        len = blk_len[pg];
        blk_len[pg] = 0;
        cls_link[pg] = cls_live[len-1] ? cls_head[len-1] : pg;
        cls_head[len-1] = pg;
        cls_live[len-1] = 1'b1;
        r.status = ST_FREED;
      end else begin
        r.status = ST_BADFREE;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready_seen) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_ready_seen <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready)
      expected_grants = {expected_grants, predict_grant(in_data)};
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_grants.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(out_data), 64'd0);
      end else begin
        want = expected_grants.pop_front();
        if (out_data.status != want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
        if (out_data.granted_offset != want.granted_offset)
          report_mismatch("granted_offset", 64'(out_data.granted_offset),
                          64'(want.granted_offset));
        if (out_data.granted_pages != want.granted_pages)
          report_mismatch("granted_pages", 64'(out_data.granted_pages),
                          64'(want.granted_pages));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("page_allocator_size_class_reuse_core regression: fail");
      $finish;
    end
  end

  function automatic in_t mk_alloc(logic [31:0] b);
    in_t t;
    t = '0;
    t.cmd = CMD_ALLOC;
    t.request_bytes = b;
    t.block_offset = 26'($urandom);
    return t;
  endfunction

  function automatic in_t mk_free(logic [25:0] o);
    in_t t;
    t.cmd = CMD_FREE;
    t.request_bytes = $urandom;
    t.block_offset = o;
    return t;
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_grants.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_pool(logic [10:0] v);
    @(negedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    pool_sz = 32'(v);
  endtask

  // mostly allocs of small sizes and frees of live blocks, with some noise
  task automatic queue_random(int n);
    int unsigned pick;
    int unsigned j;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        enqueue(mk_alloc($urandom_range(6 * 65536)));
      end else if (pick < 50) begin
        enqueue(mk_alloc($urandom));
      end else if (pick < 90 && live_blocks.size() > 0) begin
        // plan a free of a block granted earlier, possibly unaligned
        j = $urandom_range(live_blocks.size() - 1);
        enqueue(mk_free(26'((live_blocks[j] << PAGE_SHIFT)
                            | ($urandom_range(3) == 0 ? $urandom_range(65535) : 0))));
        live_blocks.delete(j);
      end else begin
        enqueue(mk_free(26'($urandom)));
      end
      // keep the plan loosely in step with the model
      while (pending_reqs.size() > 8) @(posedge clk);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    hold_off = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_ready_seen = 1'b0;
    pool_sz = 1024;
    bump = 0;
    for (int i = 0; i < MAX_PAGES; i++) begin
      blk_len[i] = 0;
      cls_head[i] = 0;
      cls_link[i] = 0;
      cls_live[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, exact reuse, larger class, bad frees, oversize
    set_pool(11'd8);
    enqueue(mk_alloc(32'd0));
    enqueue(mk_alloc(32'd65536));
    enqueue(mk_alloc(32'd65537));
    enqueue(mk_alloc(32'hFFFF_FFFF));
    enqueue(mk_free(26'h0_0001_23));
    enqueue(mk_free(26'h002_0000));
    enqueue(mk_free(26'h002_0000));
    enqueue(mk_free(26'h3FF_FFFF));
    enqueue(mk_alloc(32'd1));
    enqueue(mk_alloc(32'd3 * 65536));
    enqueue(mk_alloc(32'd1));
    enqueue(mk_alloc(32'd1));
    enqueue(mk_free(26'h001_0000));
    enqueue(mk_alloc(32'd100));
    drain();
    // shrunken pool below the bump pointer
    set_pool(11'd1);
    enqueue(mk_alloc(32'd1));
    enqueue(mk_free(26'h000_0000));
    enqueue(mk_alloc(32'd2));
    drain();
    set_pool(11'd2047);
    enqueue(mk_alloc(32'd1000 * 65536));
    enqueue(mk_alloc(32'h03FF_FFFF));
    drain();
    set_pool(11'd1024);

    // random phases with varied idling
    send_idle_pct = 0;  recv_stall_pct = 0;  queue_random(400);
    send_idle_pct = 85; recv_stall_pct = 0;  queue_random(300);
    send_idle_pct = 0;  recv_stall_pct = 85; queue_random(300);
    drain();
    set_pool(11'd64);
    send_idle_pct = 37; recv_stall_pct = 37; queue_random(400);
    // long receiver hold-off while the sender keeps offering
    hold_off = 300;
    send_idle_pct = 0;  recv_stall_pct = 0;  queue_random(200);
    drain();
    set_pool(11'd1024);
    send_idle_pct = 20; recv_stall_pct = 20; queue_random(300);
    drain();

    if (errors == 0) begin
      $display("page_allocator_size_class_reuse_core regression: pass");
    end else begin
      $display("page_allocator_size_class_reuse_core regression: fail");
    end
    $finish;
  end

endmodule
